// File: hdl/lorawan_channel_table_picker_macros.svh
// Assertion macros shared by the channel table picker RTL.
// No dependencies; included by files that carry concurrent assertions.
`ifndef LORAWAN_CHANNEL_TABLE_PICKER_MACROS_SVH
`define LORAWAN_CHANNEL_TABLE_PICKER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LCTP_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// Unconditional invariant, disabled while reset is asserted.
`define LCTP_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond)) \
		else $error(msg);

`endif

// File: hdl/lctp_pkg.sv
// Package for the channel table picker: payload structs, command codes,
// register indexes and sizing constants. No dependencies.
package lctp_pkg;

	// Sizing defaults for the top-level parameters.
	localparam int NUM_CHANNELS_DEF = 16;
	localparam int NUM_DEFAULTS_DEF = 3;

	// Field widths.
	localparam int FREQ_W   = 31;
	localparam int WORD_W   = 24;
	localparam int SLOT_W   = 3;
	localparam int RND_W    = 32;
	localparam int CMD_W    = 2;
	localparam int CFG_IDX_W = 2;

	// CFList entries start at table entry three and cover five slots.
	localparam int CFLIST_BASE  = 3;
	localparam int CFLIST_SLOTS = 5;
	// CFList words are in units of 100 Hz.
	localparam int FREQ_SCALE   = 100;

	// Command codes; code 3 is ignored.
	typedef enum logic [CMD_W-1:0] {
		CMD_INIT   = 2'd0,
		CMD_CFLIST = 2'd1,
		CMD_PICK   = 2'd2
	} cmd_t;

	// Configuration register indexes; index 3 is ignored.
	localparam logic [CFG_IDX_W-1:0] REG_DFLT_A = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DFLT_B = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DFLT_C = 2'd2;

	// Reset values of the default frequencies.
	localparam logic [FREQ_W-1:0] DFLT_A_RST = 31'd868100000;
	localparam logic [FREQ_W-1:0] DFLT_B_RST = 31'd868300000;
	localparam logic [FREQ_W-1:0] DFLT_C_RST = 31'd868500000;

	typedef struct packed {
		logic [CMD_W-1:0]  cmd;
		logic [WORD_W-1:0] cflist_word;
		logic [SLOT_W-1:0] cflist_slot;
		logic [RND_W-1:0]  random_value;
	} in_item_t;

	typedef struct packed {
		logic [FREQ_W-1:0] channel_freq;
		logic              no_channel;
	} out_item_t;

endpackage

// File: hdl/lctp_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module lctp_ram #(
	parameter int WIDTH = 31,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Read port; data holds until the next read.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// File: hdl/lorawan_channel_table_picker.sv
// Top level of the channel table picker: command decoder, scan sequencer,
// bit-serial modulo unit and output register. Depends on lctp_pkg, lctp_ram
// and lorawan_channel_table_picker_macros.svh.
//
//   Channel   Direction  Handshake           Payload
//   cfg       in         cfg_we              cfg_index, cfg_data
//   in        in         in_valid/in_ready   in_data (in_item_t)
//   out       out        out_valid/out_ready out_data (out_item_t)
//
// Init writes the default entries in S_INIT after its transfer; a CFList load is written on transfer.
// A pick runs through the transfer cycle, one used-bit scan to count, 32 steps of the
// restoring modulo, a scan to the chosen entry and one RAM read; on an empty table it
// goes from the count scan straight to the output stage.
// Reset clears the used bits at once; no clearing pass.
// A finished result waits in the output register while the next item is taken;
// a further pick holds its result stage until that register is free.
module lorawan_channel_table_picker #(
	parameter int NUM_CHANNELS = lctp_pkg::NUM_CHANNELS_DEF,
	parameter int NUM_DEFAULTS = lctp_pkg::NUM_DEFAULTS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [lctp_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [lctp_pkg::FREQ_W-1:0]         cfg_data,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  lctp_pkg::in_item_t                  in_data,
	output logic                                out_valid,
	input  logic                                out_ready,
	output lctp_pkg::out_item_t                 out_data
);

	import lctp_pkg::*;

	`include "lorawan_channel_table_picker_macros.svh"

	localparam int IW  = $clog2(NUM_CHANNELS);
	localparam int CW  = $clog2(NUM_CHANNELS + 1);
	localparam int BW  = $clog2(RND_W);
	localparam logic [IW-1:0] LAST_IDX = IW'(NUM_CHANNELS - 1);
	localparam logic [IW-1:0] LAST_DFLT = IW'(NUM_DEFAULTS - 1);
	localparam logic [BW-1:0] LAST_BIT = BW'(RND_W - 1);

	typedef enum logic [2:0] {
		S_IDLE,
		S_INIT,
		S_COUNT,
		S_DIV,
		S_FIND,
		S_OUT
	} state_t;

	state_t                  state_q;
	logic [FREQ_W-1:0]       dflt_a_q, dflt_b_q, dflt_c_q;
	logic [NUM_CHANNELS-1:0] used_q;
	logic [IW-1:0]           idx_q;
	logic [CW-1:0]           count_q;
	logic [CW-1:0]           rem_q;
	logic [CW-1:0]           seen_q;
	logic [RND_W-1:0]        rnd_q;
	logic [BW-1:0]           bit_q;
	logic                    nochan_q;
	logic                    out_valid_q;
	out_item_t               out_q;

	logic                    in_xfer;
	logic [IW:0]             cfl_entry;
	logic                    cfl_ok;
	logic [FREQ_W-1:0]       cfl_freq;
	logic [FREQ_W-1:0]       dflt_sel;
	logic [CW-1:0]           count_nx;
	logic [CW:0]             trial;
	logic                    trial_ge;
	logic [CW-1:0]           rem_nx;
	logic                    find_hit;
	logic                    ram_we;
	logic [IW-1:0]           ram_waddr;
	logic [FREQ_W-1:0]       ram_wdata;
	logic                    ram_re;
	logic [FREQ_W-1:0]       ram_rdata;
	logic                    out_free;

	// Input handshake: items are taken only while the sequencer is idle.
	assign in_ready = (state_q == S_IDLE);
	assign in_xfer  = in_valid && in_ready;

	// CFList decode: target entry, range check and scaling to Hz.
	assign cfl_entry = (IW+1)'(in_data.cflist_slot) + (IW+1)'(CFLIST_BASE);
	assign cfl_ok    = (in_data.cflist_slot < SLOT_W'(CFLIST_SLOTS))
		&& (cfl_entry < (IW+1)'(NUM_CHANNELS));
	assign cfl_freq  = FREQ_W'(in_data.cflist_word) * FREQ_W'(FREQ_SCALE);

	// Default frequency for the entry being initialized.
	always_comb begin
		case (idx_q[CFG_IDX_W-1:0])
			REG_DFLT_A: dflt_sel = dflt_a_q;
			REG_DFLT_B: dflt_sel = dflt_b_q;
			default:    dflt_sel = dflt_c_q;
		endcase
	end

	// Running count of used entries during the count scan.
	assign count_nx = count_q + CW'(used_q[idx_q]);

	// One restoring step of random_value mod count.
	assign trial    = {rem_q, rnd_q[RND_W-1]};
	assign trial_ge = (trial >= {1'b0, count_q});
	assign rem_nx   = trial_ge ? CW'(trial - {1'b0, count_q}) : trial[CW-1:0];

	// The chosen entry is the used one whose rank equals the remainder.
	assign find_hit = used_q[idx_q] && (seen_q == rem_q);

	// RAM port control: init sweep or CFList write, and the final read of a pick.
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = idx_q;
		ram_wdata = dflt_sel;
		if (state_q == S_INIT) begin
			ram_we = 1'b1;
		end else if (in_xfer && (in_data.cmd == CMD_CFLIST) && cfl_ok) begin
			ram_we    = 1'b1;
			ram_waddr = cfl_entry[IW-1:0];
			ram_wdata = cfl_freq;
		end
	end

	assign ram_re   = (state_q == S_FIND) && find_hit;
	assign out_free = !out_valid_q || out_ready;

	lctp_ram #(
		.WIDTH(FREQ_W),
		.DEPTH(NUM_CHANNELS)
	) u_table (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(idx_q),
		.rdata(ram_rdata)
	);

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dflt_a_q <= DFLT_A_RST;
			dflt_b_q <= DFLT_B_RST;
			dflt_c_q <= DFLT_C_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_DFLT_A: dflt_a_q <= cfg_data;
				REG_DFLT_B: dflt_b_q <= cfg_data;
				REG_DFLT_C: dflt_c_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Sequencer, used bits and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			used_q      <= '0;
			idx_q       <= '0;
			count_q     <= '0;
			rem_q       <= '0;
			seen_q      <= '0;
			rnd_q       <= '0;
			bit_q       <= '0;
			nochan_q    <= 1'b0;
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else begin
			// The output register empties on its transfer unless a new result loads it.
			if (out_valid_q && out_ready && !(state_q == S_OUT && out_free)) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_xfer) begin
						unique case (in_data.cmd)
							CMD_INIT: begin
								used_q  <= '0;
								idx_q   <= '0;
								state_q <= S_INIT;
							end
							CMD_CFLIST: begin
								if (cfl_ok) begin
									used_q[cfl_entry[IW-1:0]] <= (in_data.cflist_word != '0);
								end
							end
							CMD_PICK: begin
								rnd_q   <= in_data.random_value;
								count_q <= '0;
								idx_q   <= '0;
								state_q <= S_COUNT;
							end
							default: ;
						endcase
					end
				end
				S_INIT: begin
					used_q[idx_q] <= (dflt_sel != '0);
					if (idx_q == LAST_DFLT) begin
						state_q <= S_IDLE;
					end else begin
						idx_q <= idx_q + IW'(1);
					end
				end
				S_COUNT: begin
					count_q <= count_nx;
					if (idx_q == LAST_IDX) begin
						if (count_nx == '0) begin
							nochan_q <= 1'b1;
							state_q  <= S_OUT;
						end else begin
							rem_q   <= '0;
							bit_q   <= '0;
							state_q <= S_DIV;
						end
					end else begin
						idx_q <= idx_q + IW'(1);
					end
				end
				S_DIV: begin
					rem_q <= rem_nx;
					rnd_q <= {rnd_q[RND_W-2:0], 1'b0};
					bit_q <= bit_q + BW'(1);
					if (bit_q == LAST_BIT) begin
						idx_q   <= '0;
						seen_q  <= '0;
						state_q <= S_FIND;
					end
				end
				S_FIND: begin
					if (find_hit) begin
						nochan_q <= 1'b0;
						state_q  <= S_OUT;
					end else begin
						if (used_q[idx_q]) begin
							seen_q <= seen_q + CW'(1);
						end
						idx_q <= idx_q + IW'(1);
					end
				end
				S_OUT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						if (nochan_q) begin
							out_q.channel_freq <= '0;
							out_q.no_channel   <= 1'b1;
						end else begin
							out_q.channel_freq <= ram_rdata;
							out_q.no_channel   <= 1'b0;
						end
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// The used count can never exceed the table size.
	`LCTP_ASSERT_ALWAYS(a_count_bound, clk, arst_n, count_q <= CW'(NUM_CHANNELS), "used count exceeds table size")
	// After the modulo steps the remainder must be below the count.
	`LCTP_ASSERT_IMP(a_rem_below_count, clk, arst_n, state_q == S_FIND, rem_q < count_q, "remainder not below count")
	// The selection scan must not run past the last entry without a hit.
	`LCTP_ASSERT_IMP(a_find_in_range, clk, arst_n, state_q == S_FIND && idx_q == LAST_IDX, find_hit, "pick scan ran off the table")
	// A result flagged as having no channel carries a zero frequency.
	`LCTP_ASSERT_IMP(a_nochan_zero, clk, arst_n, out_valid_q && out_q.no_channel, out_q.channel_freq == '0, "no_channel with nonzero frequency")

endmodule

// File: bench/lctp_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the channel table picker: mirrors the channel table from the
// configuration writes and input transfers, predicts every pick and compares.
// Depends on lctp_pkg only.
module lctp_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [lctp_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [lctp_pkg::FREQ_W-1:0]    cfg_data,
	input  logic                           in_valid,
	input  logic                           in_ready,
	input  lctp_pkg::in_item_t             in_data,
	input  logic                           out_valid,
	input  logic                           out_ready,
	input  lctp_pkg::out_item_t            out_data,
	output int                             mismatch_count,
	output int                             picks_pending,
	output int                             picks_checked,
	output int                             empty_picks
);

	import lctp_pkg::*;

	localparam int TABLE_SIZE    = NUM_CHANNELS_DEF;
	localparam int DEFAULTS_USED = NUM_DEFAULTS_DEF;

	// Mirror of the block state.
	logic [FREQ_W-1:0] freq_table [TABLE_SIZE];
	logic [FREQ_W-1:0] default_freq [3];

	// Pick results still owed by the block, oldest first.
	out_item_t pick_q [$];

	int errors;
	int checked;
	int empties;

	// Count the used entries, then walk to used entry (rnd mod count).
	function automatic out_item_t choose_channel(logic [RND_W-1:0] rnd);
		out_item_t   pick;
		int unsigned used;
		int unsigned target;
		int unsigned seen;
		used = 0;
		seen = 0;
		pick.channel_freq = '0;
		pick.no_channel   = 1'b0;
		for (int i = 0; i < TABLE_SIZE; i++)
			if (freq_table[i] != '0)
				used++;
		if (used == 0) begin
			pick.no_channel = 1'b1;
			return pick;
		end
		target = rnd % used;
		for (int i = 0; i < TABLE_SIZE; i++) begin
			if (freq_table[i] != '0) begin
				if (seen == target) begin
					pick.channel_freq = freq_table[i];
					break;
				end
				seen++;
			end
		end
		return pick;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		out_item_t   want;
		int unsigned entry;
		if (!arst_n) begin
			for (int i = 0; i < TABLE_SIZE; i++)
				freq_table[i] = '0;
			default_freq[0] = DFLT_A_RST;
			default_freq[1] = DFLT_B_RST;
			default_freq[2] = DFLT_C_RST;
			pick_q.delete();
			errors  = 0;
			checked = 0;
			empties = 0;
		end else begin
			// Check the result side first so a queue never pops what this edge pushes.
			if (out_valid && out_ready) begin
				checked++;
				if (pick_q.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("[%0t] result with none pending: freq %0d no_channel %0b",
							$realtime, out_data.channel_freq, out_data.no_channel);
				end else begin
					want = pick_q.pop_front();
					if (want.no_channel)
						empties++;
					if (out_data.channel_freq !== want.channel_freq ||
						out_data.no_channel !== want.no_channel) begin
						errors++;
						if (errors <= 10)
							$display("[%0t] pick mismatch: expected freq %0d no_channel %0b, got freq %0d no_channel %0b",
								$realtime, want.channel_freq, want.no_channel,
								out_data.channel_freq, out_data.no_channel);
					end
				end
			end

			// Users write registers only while the block is idle; not enforced here.
			if (cfg_we && cfg_index <= REG_DFLT_C)
				default_freq[cfg_index] = cfg_data;

			// Apply each input transfer to the mirrored table.
			if (in_valid && in_ready) begin
				case (in_data.cmd)
					CMD_INIT: begin
						for (int i = 0; i < TABLE_SIZE; i++)
							freq_table[i] = (i < DEFAULTS_USED) ? default_freq[i] : '0;
					end
					CMD_CFLIST: begin
						entry = CFLIST_BASE + in_data.cflist_slot;
						if (in_data.cflist_slot < CFLIST_SLOTS && entry < TABLE_SIZE)
							freq_table[entry] = FREQ_W'(in_data.cflist_word * 32'(FREQ_SCALE));
					end
					CMD_PICK: begin
						pick_q.push_back(choose_channel(in_data.random_value));
					end
					default: begin
					end
				endcase
			end
		end
		mismatch_count <= errors;
		picks_pending  <= pick_q.size();
		picks_checked  <= checked;
		empty_picks    <= empties;
	end

endmodule

// File: bench/lorawan_channel_table_picker_test.sv
`timescale 1ns / 1ps
// Top of the channel table picker testbench: clock, reset, register writes,
// directed and random command stimulus, output stalls and the verdict.
// Depends on lctp_pkg, lorawan_channel_table_picker and lctp_checker.
module lorawan_channel_table_picker_test;
	import lctp_pkg::*;

	localparam logic [CMD_W-1:0]     CMD_UNUSED  = 2'd3;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED  = 2'd3;
	localparam logic [FREQ_W-1:0]    FREQ_TOP    = 31'd1677721500;
	localparam logic [WORD_W-1:0]    WORD_TOP    = '1;
	localparam logic [RND_W-1:0]     RND_TOP     = '1;
	localparam int                   PHASES      = 5;
	localparam int                   PHASE_ITEMS = 155;
	localparam int                   SETTLE      = 8;
	localparam int                   CYCLE_LIMIT = 400000;

	logic      clk       = 1'b0;
	logic      arst_n    = 1'b0;
	logic      cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [FREQ_W-1:0]    cfg_data  = '0;
	logic      in_valid  = 1'b0;
	logic      in_ready;
	in_item_t  in_data   = '0;
	logic      out_valid;
	logic      out_ready = 1'b0;
	out_item_t out_data;

	// Stretches with no idling on either side.
	logic no_idle = 1'b0;

	int rx_hold;
	int cycles;
	int useful_sent;
	int inits_sent;
	int loads_sent;
	int picks_sent;
	int ignored_sent;
	int settings_used;

	int mismatch_count;
	int picks_pending;
	int picks_checked;
	int empty_picks;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	lorawan_channel_table_picker u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	lctp_checker u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.in_data        (in_data),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.out_data       (out_data),
		.mismatch_count (mismatch_count),
		.picks_pending  (picks_pending),
		.picks_checked  (picks_checked),
		.empty_picks    (empty_picks)
	);

	// Result side: after each transfer, hold ready low for a random time, none at all while no_idle is set.
	always @(posedge clk or negedge arst_n) begin
		int hold_next;
		if (!arst_n) begin
			rx_hold   <= 0;
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready)
				hold_next = no_idle ? 0 : $urandom_range(0, 5);
			else
				hold_next = (rx_hold > 0) ? rx_hold - 1 : 0;
			rx_hold   <= hold_next;
			out_ready <= (hold_next == 0);
		end
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("run stopped after %0d cycles with %0d picks pending", cycles, picks_pending);
			$display("end of test: mismatches");
			$finish;
		end
	end

	function automatic in_item_t make_item(logic [CMD_W-1:0] cmd, logic [WORD_W-1:0] word,
		logic [SLOT_W-1:0] slot, logic [RND_W-1:0] rnd);
		in_item_t it;
		it.cmd          = cmd;
		it.cflist_word  = word;
		it.cflist_slot  = slot;
		it.random_value = rnd;
		return it;
	endfunction

	// Mostly loads and picks over a table that init refills now and then; a
	// few items carry an unused command or a slot past the CFList.
	function automatic in_item_t random_item();
		in_item_t    it;
		int unsigned roll;
		it = make_item(CMD_PICK, WORD_W'($urandom), SLOT_W'($urandom_range(0, 4)), $urandom);
		roll = $urandom_range(0, 99);
		if (roll < 4)
			it.cmd = CMD_INIT;
		else if (roll < 42)
			it.cmd = CMD_CFLIST;
		else if (roll >= 96)
			it.cmd = CMD_UNUSED;
		if ($urandom_range(0, 9) == 0)
			it.cflist_slot = SLOT_W'($urandom_range(5, 7));
		roll = $urandom_range(0, 19);
		if (roll == 0)
			it.cflist_word = '0;
		else if (roll == 1)
			it.cflist_word = WORD_TOP;
		roll = $urandom_range(0, 19);
		if (roll == 0)
			it.random_value = '0;
		else if (roll == 1)
			it.random_value = RND_TOP;
		else if (roll < 6)
			it.random_value = RND_W'($urandom_range(0, 40));
		return it;
	endfunction

	// One input transfer, preceded by a random gap. Valid stays high between
	// back-to-back items; anything that waits afterwards lowers it first.
	task automatic send_item(in_item_t it);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 5);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= it;
		do @(posedge clk); while (!in_ready);
		case (it.cmd)
			CMD_INIT:   inits_sent++;
			CMD_CFLIST: begin
				if (it.cflist_slot < CFLIST_SLOTS)
					loads_sent++;
				else
					ignored_sent++;
			end
			CMD_PICK:   picks_sent++;
			default:    ignored_sent++;
		endcase
		if (!(it.cmd == CMD_UNUSED || (it.cmd == CMD_CFLIST && it.cflist_slot >= CFLIST_SLOTS)))
			useful_sent++;
	endtask

	// Stop sending and wait until every pick result has come back, then give
	// a trailing init or load time to finish.
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (picks_pending != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [FREQ_W-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
	endtask

	task automatic set_defaults(logic [FREQ_W-1:0] a, logic [FREQ_W-1:0] b,
		logic [FREQ_W-1:0] c);
		write_reg(REG_DFLT_A, a);
		write_reg(REG_DFLT_B, b);
		write_reg(REG_DFLT_C, c);
		cfg_we <= 1'b0;
		settings_used++;
	endtask

	function automatic logic [FREQ_W-1:0] random_freq();
		if ($urandom_range(0, 3) == 0)
			return '0;
		return FREQ_W'($urandom_range(FREQ_TOP, 0));
	endfunction

	initial begin
		int start;
		bit paused;
		settings_used = 1;
		paused = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Empty table after reset, ignored items, then a single used entry.
		send_item(make_item(CMD_PICK, '0, '0, '0));
		send_item(make_item(CMD_PICK, WORD_TOP, '1, RND_TOP));
		send_item(make_item(CMD_UNUSED, WORD_TOP, '1, RND_TOP));
		send_item(make_item(CMD_CFLIST, WORD_TOP, 3'd7, '0));
		send_item(make_item(CMD_CFLIST, 24'd1, 3'd2, '0));
		send_item(make_item(CMD_PICK, '0, '0, RND_TOP));
		// Defaults, with the pick index wrapping over three entries.
		send_item(make_item(CMD_INIT, '0, '0, '0));
		send_item(make_item(CMD_PICK, '0, '0, 32'd0));
		send_item(make_item(CMD_PICK, '0, '0, 32'd1));
		send_item(make_item(CMD_PICK, '0, '0, 32'd2));
		send_item(make_item(CMD_PICK, '0, '0, 32'd3));
		// Fill every CFList slot, largest word first.
		send_item(make_item(CMD_CFLIST, WORD_TOP, 3'd0, '0));
		send_item(make_item(CMD_CFLIST, 24'h123456, 3'd1, '0));
		send_item(make_item(CMD_CFLIST, 24'h5A5A5A, 3'd2, '0));
		send_item(make_item(CMD_CFLIST, 24'h00FFFF, 3'd3, '0));
		send_item(make_item(CMD_CFLIST, 24'h800000, 3'd4, '0));
		send_item(make_item(CMD_PICK, '0, '0, 32'd7));
		send_item(make_item(CMD_PICK, '0, '0, RND_TOP));
		// A zero word frees its entry; slots past the CFList change nothing.
		send_item(make_item(CMD_CFLIST, '0, 3'd0, '0));
		send_item(make_item(CMD_PICK, '0, '0, 32'd3));
		send_item(make_item(CMD_CFLIST, WORD_TOP, 3'd5, '0));
		send_item(make_item(CMD_CFLIST, WORD_TOP, 3'd6, '0));
		send_item(make_item(CMD_PICK, '0, '0, 32'h8000_0000));

		// Random phases, each under its own set of default frequencies.
		for (int phase = 0; phase < PHASES; phase++) begin
			if (phase > 0) begin
				drain();
				case (phase)
					1: set_defaults('0, '0, '0);
					2: set_defaults(FREQ_TOP, FREQ_TOP, FREQ_TOP);
					3: begin
						write_reg(REG_UNUSED, FREQ_W'($urandom));
						set_defaults(random_freq(), random_freq(), random_freq());
					end
					default: set_defaults(FREQ_TOP, '0, random_freq());
				endcase
				send_item(make_item(CMD_INIT, WORD_W'($urandom), SLOT_W'($urandom), $urandom));
			end
			start = useful_sent;
			while (useful_sent - start < PHASE_ITEMS) begin
				if ((useful_sent - start) % 30 == 0)
					no_idle <= ($urandom_range(0, 3) == 0);
				// Let the block run dry once in the middle of a phase.
				if (phase == 2 && !paused && useful_sent - start >= 60) begin
					paused = 1'b1;
					drain();
				end
				send_item(random_item());
			end
		end

		drain();
		no_idle <= 1'b0;
		$display("Sent %0d items: %0d inits, %0d CFList loads, %0d picks, %0d ignored, under %0d default settings.",
			inits_sent + loads_sent + picks_sent + ignored_sent, inits_sent, loads_sent,
			picks_sent, ignored_sent, settings_used);
		$display("Checked %0d pick results, %0d of them on an empty table.",
			picks_checked, empty_picks);
		if (mismatch_count == 0 && picks_pending == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
